// File: hdl/bdeq_pkg.sv
// Shared constants and transaction types for the byte double-ended queue.
// Used by byte_double_ended_queue_core; depends on nothing.
package bdeq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int ACTION_W = 3;
	localparam int BYTE_W   = 8;
	localparam int ECNT_W   = 5;

	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_QUERY      = 3'd4;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [BYTE_W-1:0]   push_value;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] popped_value;
		logic [BYTE_W-1:0] front_value;
		logic [BYTE_W-1:0] back_value;
		logic [ECNT_W-1:0] entry_count;
		logic              empty_flag;
		logic              full_flag;
		logic              rejected;
	} rsp_t;

endpackage

// File: hdl/byte_double_ended_queue_core.sv
// Byte double-ended queue: circular entry RAM plus head/count and cached end bytes.
// Depends on bdeq_pkg and bdeq_ram.
//
//   channel | valid     | stall     | payload            | role
//   --------+-----------+-----------+--------------------+----------------------------
//   request | req_valid | req_stall | req  (bdeq_pkg::req_t) | one action per transaction
//   result  | rsp_valid | rsp_stall | rsp  (bdeq_pkg::rsp_t) | one result per request
//
// Push, query, unused and rejected actions form their result from the request itself;
// a pop that leaves bytes behind waits in ST_READ for the registered end-byte RAM read.
// A result waits in the output register; while it is stalled one more result
// can be parked, after which req_stall stays high until the output drains.
// Reset clears head, count, state and valid flags; the entry RAM is not cleared.
module byte_double_ended_queue_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  bdeq_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output bdeq_pkg::rsp_t   rsp
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t st_q, st_d;

	logic [bdeq_pkg::IDX_W-1:0]  head_q, head_d;
	logic [bdeq_pkg::CNT_W-1:0]  cnt_q, cnt_d;
	logic [bdeq_pkg::BYTE_W-1:0] front_q, front_d;
	logic [bdeq_pkg::BYTE_W-1:0] back_q, back_d;

	logic                        front_pop_s1;
	logic [bdeq_pkg::BYTE_W-1:0] popped_s1;

	bdeq_pkg::rsp_t pend_q;
	bdeq_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	logic                        acc;
	logic                        full;
	logic                        empty;
	logic                        go_read;
	logic                        rej;
	logic [bdeq_pkg::BYTE_W-1:0] popped;
	logic                        wr_en;
	logic [bdeq_pkg::IDX_W-1:0]  wr_addr;
	logic                        rd_en;
	logic [bdeq_pkg::IDX_W-1:0]  rd_addr;
	logic [bdeq_pkg::BYTE_W-1:0] rd_data;
	logic [bdeq_pkg::IDX_W-1:0]  head_dec;
	logic [bdeq_pkg::IDX_W-1:0]  head_inc;
	logic                        out_free;
	logic                        res_valid;
	bdeq_pkg::rsp_t              res;

	// (base + off) mod CAPACITY, with off below CAPACITY
	function automatic logic [bdeq_pkg::IDX_W-1:0] wrap_idx(
		input logic [bdeq_pkg::IDX_W-1:0] base,
		input logic [bdeq_pkg::CNT_W-1:0] off
	);
		logic [bdeq_pkg::CNT_W:0] sum;
		sum = (bdeq_pkg::CNT_W+1)'(base) + (bdeq_pkg::CNT_W+1)'(off);
		if (sum >= (bdeq_pkg::CNT_W+1)'(bdeq_pkg::CAPACITY)) begin
			sum = sum - (bdeq_pkg::CNT_W+1)'(bdeq_pkg::CAPACITY);
		end
		return bdeq_pkg::IDX_W'(sum);
	endfunction

	function automatic bdeq_pkg::rsp_t make_rsp(
		input logic [bdeq_pkg::BYTE_W-1:0] pop_v,
		input logic [bdeq_pkg::BYTE_W-1:0] fr_v,
		input logic [bdeq_pkg::BYTE_W-1:0] bk_v,
		input logic [bdeq_pkg::CNT_W-1:0]  cnt,
		input logic                        rj
	);
		bdeq_pkg::rsp_t r;
		logic           no_bytes;
		no_bytes       = (cnt == '0);
		r.popped_value = pop_v;
		r.front_value  = no_bytes ? '0 : fr_v;
		r.back_value   = no_bytes ? '0 : bk_v;
		r.entry_count  = bdeq_pkg::ECNT_W'(cnt);
		r.empty_flag   = no_bytes;
		r.full_flag    = (cnt == bdeq_pkg::CNT_W'(bdeq_pkg::CAPACITY));
		r.rejected     = rj;
		return r;
	endfunction

	assign acc       = req_valid && (st_q == ST_IDLE);
	assign req_stall = (st_q != ST_IDLE);
	assign full      = (cnt_q == bdeq_pkg::CNT_W'(bdeq_pkg::CAPACITY));
	assign empty     = (cnt_q == '0);
	assign head_dec  = wrap_idx(head_q, bdeq_pkg::CNT_W'(bdeq_pkg::CAPACITY - 1));
	assign head_inc  = wrap_idx(head_q, bdeq_pkg::CNT_W'(1));
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		head_d  = head_q;
		cnt_d   = cnt_q;
		front_d = front_q;
		back_d  = back_q;
		wr_en   = 1'b0;
		wr_addr = head_q;
		rd_en   = 1'b0;
		rd_addr = head_q;
		popped  = '0;
		rej     = 1'b0;
		go_read = 1'b0;
		if (acc) begin
			case (req.action)
				bdeq_pkg::ACT_PUSH_FRONT: begin
					if (full) begin
						rej = 1'b1;
					end else begin
						wr_en   = 1'b1;
						wr_addr = head_dec;
						head_d  = head_dec;
						cnt_d   = cnt_q + bdeq_pkg::CNT_W'(1);
						front_d = req.push_value;
						if (empty) begin
							back_d = req.push_value;
						end
					end
				end
				bdeq_pkg::ACT_PUSH_BACK: begin
					if (full) begin
						rej = 1'b1;
					end else begin
						wr_en   = 1'b1;
						wr_addr = wrap_idx(head_q, cnt_q);
						cnt_d   = cnt_q + bdeq_pkg::CNT_W'(1);
						back_d  = req.push_value;
						if (empty) begin
							front_d = req.push_value;
						end
					end
				end
				bdeq_pkg::ACT_POP_FRONT: begin
					if (empty) begin
						rej = 1'b1;
					end else begin
						popped = front_q;
						head_d = head_inc;
						cnt_d  = cnt_q - bdeq_pkg::CNT_W'(1);
						// fetch the new front byte unless the queue drains
						if (cnt_q != bdeq_pkg::CNT_W'(1)) begin
							rd_en   = 1'b1;
							rd_addr = head_inc;
							go_read = 1'b1;
						end
					end
				end
				bdeq_pkg::ACT_POP_BACK: begin
					if (empty) begin
						rej = 1'b1;
					end else begin
						popped = back_q;
						cnt_d  = cnt_q - bdeq_pkg::CNT_W'(1);
						if (cnt_q != bdeq_pkg::CNT_W'(1)) begin
							rd_en   = 1'b1;
							rd_addr = wrap_idx(head_q, cnt_q - bdeq_pkg::CNT_W'(2));
							go_read = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end else if (st_q == ST_READ) begin
			if (front_pop_s1) begin
				front_d = rd_data;
			end else begin
				back_d = rd_data;
			end
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = pend_q;
		st_d      = st_q;
		case (st_q)
			ST_IDLE: begin
				if (acc && go_read) begin
					st_d = ST_READ;
				end else if (acc) begin
					res_valid = 1'b1;
					res       = make_rsp(popped, front_d, back_d, cnt_d, rej);
					if (!out_free) begin
						st_d = ST_HOLD;
					end
				end
			end
			ST_READ: begin
				res_valid = 1'b1;
				res       = make_rsp(popped_s1, front_d, back_d, cnt_q, 1'b0);
				st_d      = out_free ? ST_IDLE : ST_HOLD;
			end
			ST_HOLD: begin
				res_valid = 1'b1;
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			head_q <= head_d;
			cnt_q  <= cnt_d;
			if (out_free) begin
				rsp_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		front_q <= front_d;
		back_q  <= back_d;
		if (acc) begin
			front_pop_s1 <= (req.action == bdeq_pkg::ACT_POP_FRONT);
			popped_s1    <= popped;
		end
		// park the result while the output register is stalled
		if (res_valid && !out_free) begin
			pend_q <= res;
		end
		if (res_valid && out_free) begin
			rsp_q <= res;
		end
	end

	bdeq_ram #(
		.WIDTH(bdeq_pkg::BYTE_W),
		.DEPTH(bdeq_pkg::CAPACITY)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(req.push_value),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= bdeq_pkg::CNT_W'(bdeq_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_read_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_READ) |-> $past(acc && go_read))
		else $error("read state without a pop that needs a RAM read");

	a_hold_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_HOLD) |-> rsp_valid_q)
		else $error("result parked while output register is free");

	a_full_push_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && full && (req.action == bdeq_pkg::ACT_PUSH_FRONT ||
		req.action == bdeq_pkg::ACT_PUSH_BACK)) |=> $stable(cnt_q) && $stable(head_q))
		else $error("push on a full queue changed the state");

	a_ram_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("entry RAM written and read in the same cycle");
`endif

endmodule

// File: hdl/bdeq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module bdeq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: test/tb_byte_double_ended_queue_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for byte_double_ended_queue_core: directed and random deque actions.
// Depends on bdeq_pkg and the core RTL; a scoreboard class predicts every result.
module tb_byte_double_ended_queue_core;

	class deque_scoreboard;
		logic [bdeq_pkg::BYTE_W-1:0] slots [bdeq_pkg::CAPACITY];
		int unsigned head;
		int unsigned count;
		bdeq_pkg::rsp_t expected_q [$];
		int errors;

		function new();
			head = 0;
			count = 0;
			errors = 0;
		endfunction

		// Apply one accepted request to the local deque and queue its result.
		function void note_request(bdeq_pkg::req_t r);
			bdeq_pkg::rsp_t e;
			bit was_full;
			bit was_empty;
			e = '0;
			was_full = (count >= bdeq_pkg::CAPACITY);
			was_empty = (count == 0);
			case (r.action)
				bdeq_pkg::ACT_PUSH_FRONT: begin
					if (was_full) begin
						e.rejected = 1'b1;
					end else begin
						head = (head + bdeq_pkg::CAPACITY - 1) % bdeq_pkg::CAPACITY;
						slots[head] = r.push_value;
						count++;
					end
				end
				bdeq_pkg::ACT_PUSH_BACK: begin
					if (was_full) begin
						e.rejected = 1'b1;
					end else begin
						slots[(head + count) % bdeq_pkg::CAPACITY] = r.push_value;
						count++;
					end
				end
				bdeq_pkg::ACT_POP_FRONT: begin
					if (was_empty) begin
						e.rejected = 1'b1;
					end else begin
						e.popped_value = slots[head];
						head = (head + 1) % bdeq_pkg::CAPACITY;
						count--;
					end
				end
				bdeq_pkg::ACT_POP_BACK: begin
					if (was_empty) begin
						e.rejected = 1'b1;
					end else begin
						e.popped_value = slots[(head + count - 1) % bdeq_pkg::CAPACITY];
						count--;
					end
				end
				default: ;
			endcase
			if (count != 0) begin
				e.front_value = slots[head];
				e.back_value = slots[(head + count - 1) % bdeq_pkg::CAPACITY];
			end
			e.entry_count = bdeq_pkg::ECNT_W'(count);
			e.empty_flag = (count == 0);
			e.full_flag = (count >= bdeq_pkg::CAPACITY);
			expected_q = {expected_q, e};
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: mismatch on %s: expected %0h, actual %0h",
					$time, field, want, got);
			end
		endfunction

		function void check_result(bdeq_pkg::rsp_t got);
			bdeq_pkg::rsp_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual %h", $time, got);
			end else begin
				e = expected_q[0];
				expected_q.delete(0);
				compare_field("popped_value", 32'(e.popped_value), 32'(got.popped_value));
				compare_field("front_value", 32'(e.front_value), 32'(got.front_value));
				compare_field("back_value", 32'(e.back_value), 32'(got.back_value));
				compare_field("entry_count", 32'(e.entry_count), 32'(got.entry_count));
				compare_field("empty_flag", 32'(e.empty_flag), 32'(got.empty_flag));
				compare_field("full_flag", 32'(e.full_flag), 32'(got.full_flag));
				compare_field("rejected", 32'(e.rejected), 32'(got.rejected));
			end
		endfunction

		function void check_drained();
			if (expected_q.size() != 0) begin
				errors++;
				$display("%0t: %0d results missing: expected %h, actual none",
					$time, expected_q.size(), expected_q[0]);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	bdeq_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	bdeq_pkg::rsp_t rsp;

	deque_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;
	bit drain_timeout = 1'b0;

	byte_double_ended_queue_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Result side: random stall, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_left = 60;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
	end

	task automatic send_item(input bdeq_pkg::req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic send_action(input logic [bdeq_pkg::ACTION_W-1:0] act,
			input logic [bdeq_pkg::BYTE_W-1:0] val);
		bdeq_pkg::req_t r;
		r.action = act;
		r.push_value = val;
		send_item(r);
	endtask

	function automatic bdeq_pkg::req_t random_request(int push_bias);
		bdeq_pkg::req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.push_value = bdeq_pkg::BYTE_W'($urandom_range(0, 255));
		if (pick < 4)
			r.action = bdeq_pkg::ACTION_W'($urandom_range(5, 7));
		else if (pick < 10)
			r.action = bdeq_pkg::ACT_QUERY;
		else if ($urandom_range(0, 99) < push_bias)
			r.action = $urandom_range(0, 1) ? bdeq_pkg::ACT_PUSH_BACK : bdeq_pkg::ACT_PUSH_FRONT;
		else
			r.action = $urandom_range(0, 1) ? bdeq_pkg::ACT_POP_BACK : bdeq_pkg::ACT_POP_FRONT;
		return r;
	endfunction

	// Alternate fill-heavy, drain-heavy and balanced stretches so both ends get hit.
	task automatic run_random(input int n_items);
		int bias;
		bias = 50;
		for (int i = 0; i < n_items; i++) begin
			if (i % 24 == 0) begin
				case ($urandom_range(0, 2))
					0: bias = 20;
					1: bias = 50;
					default: bias = 80;
				endcase
			end
			send_item(random_request(bias));
		end
	endtask

	task automatic wait_drained();
		int waited;
		req_valid <= 1'b0;
		waited = 0;
		while (sb.expected_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (waited >= 20000)
			drain_timeout = 1'b1;
		repeat (4) @(posedge clk);
	endtask

	initial begin
		sb = new();
		req_valid <= 1'b0;
		req <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty deque: query, both pops rejected, unused action codes, then a push and a pop at each end.
		send_action(bdeq_pkg::ACT_QUERY, 8'h5A);
		send_action(bdeq_pkg::ACT_POP_FRONT, 8'h00);
		send_action(bdeq_pkg::ACT_POP_BACK, 8'hFF);
		send_action(3'd5, 8'hFF);
		send_action(3'd6, 8'h00);
		send_action(3'd7, 8'hFF);
		send_action(bdeq_pkg::ACT_PUSH_FRONT, 8'h00);
		send_action(bdeq_pkg::ACT_PUSH_BACK, 8'hFF);
		send_action(bdeq_pkg::ACT_POP_BACK, 8'h00);
		send_action(bdeq_pkg::ACT_POP_FRONT, 8'h00);
		// Fill to capacity from both ends, then overflow at both ends and pop one byte from each end.
		for (int k = 0; k < bdeq_pkg::CAPACITY; k++)
			send_action(k[0] ? bdeq_pkg::ACT_PUSH_BACK : bdeq_pkg::ACT_PUSH_FRONT,
				bdeq_pkg::BYTE_W'(k * 37 + 1));
		send_action(bdeq_pkg::ACT_PUSH_FRONT, 8'hAA);
		send_action(bdeq_pkg::ACT_PUSH_BACK, 8'h55);
		send_action(bdeq_pkg::ACT_POP_FRONT, 8'h00);
		send_action(bdeq_pkg::ACT_POP_BACK, 8'h00);
		wait_drained();

		// No idling, then a long hold-off on the result side while requests keep coming.
		run_random(200);
		hold_trigger++;
		run_random(30);
		wait_drained();

		send_idle_pct = 76;
		recv_stall_pct = 0;
		run_random(200);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 76;
		run_random(200);
		wait_drained();

		send_idle_pct = 34;
		recv_stall_pct = 34;
		run_random(220);
		wait_drained();

		sb.check_drained();
		if (sb.errors == 0 && !drain_timeout)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
